[rtl/core/rmcc_pkg.sv]
// Shared types and constants of the rover motor command controller.
`default_nettype none
package rmcc_pkg;

   localparam int DUTY_BITS       = 10;
   localparam int TURN_COUNT_BITS = 16;
   localparam int MOTOR_COUNT     = 4;
   localparam int BRIDGE_BITS     = 2 * MOTOR_COUNT;
   localparam int BYTE_BITS       = 8;
   localparam int REPLY_BITS      = 4;

   localparam logic [DUTY_BITS-1:0]       DUTY_MAX_VALUE  = {DUTY_BITS{1'b1}};
   localparam logic [DUTY_BITS-1:0]       MAX_DUTY_RESET  = DUTY_BITS'(1000);
   localparam logic [DUTY_BITS-1:0]       MIN_DUTY_RESET  = DUTY_BITS'(100);
   localparam logic [DUTY_BITS-1:0]       STEP_SIZE_RESET = DUTY_BITS'(50);
   localparam logic [DUTY_BITS-1:0]       TURN_DUTY_RESET = DUTY_BITS'(400);
   localparam logic [TURN_COUNT_BITS-1:0] TURN_TICKS_RESET = TURN_COUNT_BITS'(200);
   localparam logic [DUTY_BITS-1:0]       START_DUTY_RESET = DUTY_BITS'(550);

   // Bridge leg patterns: bit 2k forward leg, bit 2k+1 reverse leg of motor k+1
   localparam logic [BRIDGE_BITS-1:0] BRIDGE_OFF     = 8'h00;
   localparam logic [BRIDGE_BITS-1:0] BRIDGE_FORWARD = 8'h55;
   localparam logic [BRIDGE_BITS-1:0] BRIDGE_REVERSE = 8'hAA;
   localparam logic [BRIDGE_BITS-1:0] BRIDGE_SPIN_A  = 8'hA5;
   localparam logic [BRIDGE_BITS-1:0] BRIDGE_SPIN_B  = 8'h5A;

   // Command letters, upper case, and the bounds of the lower case range
   localparam logic [BYTE_BITS-1:0] CHAR_F = 8'h46;
   localparam logic [BYTE_BITS-1:0] CHAR_B = 8'h42;
   localparam logic [BYTE_BITS-1:0] CHAR_L = 8'h4C;
   localparam logic [BYTE_BITS-1:0] CHAR_R = 8'h52;
   localparam logic [BYTE_BITS-1:0] CHAR_U = 8'h55;
   localparam logic [BYTE_BITS-1:0] CHAR_D = 8'h44;
   localparam logic [BYTE_BITS-1:0] CHAR_S = 8'h53;
   localparam logic [BYTE_BITS-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [BYTE_BITS-1:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [BYTE_BITS-1:0] CASE_OFFSET  = 8'h20;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Register file
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_ADDR_BITS  = 5;
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_DUTY   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_DUTY   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP_SIZE  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TURN_DUTY  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TURN_TICKS = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_DUTY = 3'd5;

   // Command queue between front and back
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   typedef enum logic [3:0] {
      OP_NONE,
      OP_TICK,
      OP_FWD,
      OP_BACK,
      OP_LEFT,
      OP_RIGHT,
      OP_UP,
      OP_DOWN,
      OP_STOP
   } op_type;

   typedef enum logic [REPLY_BITS-1:0] {
      REPLY_NONE   = 4'd0,
      REPLY_FWD    = 4'd1,
      REPLY_BACK   = 4'd2,
      REPLY_LEFT   = 4'd3,
      REPLY_RIGHT  = 4'd4,
      REPLY_UP     = 4'd5,
      REPLY_DOWN   = 4'd6,
      REPLY_STOP   = 4'd7,
      REPLY_AT_MAX = 4'd8,
      REPLY_AT_MIN = 4'd9
   } reply_type;

   typedef struct packed {
      logic [DUTY_BITS-1:0]       max_duty;
      logic [DUTY_BITS-1:0]       min_duty;
      logic [DUTY_BITS-1:0]       step_size;
      logic [DUTY_BITS-1:0]       turn_duty;
      logic [TURN_COUNT_BITS-1:0] turn_ticks;
   } cfg_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } queue_entry_type;

endpackage
`default_nettype wire

[rtl/core/rmcc_req_if.sv]
// Input channel: command kind and received byte.
`default_nettype none
interface rmcc_req_if import rmcc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 command;
   logic [BYTE_BITS-1:0] rx_byte;

   modport source (output valid, output command, output rx_byte, input ready);
   modport sink   (input valid, input command, input rx_byte, output ready);
endinterface
`default_nettype wire

[rtl/core/rmcc_rsp_if.sv]
// Result channel: applied duties, bridge legs, reply code and turn flag.
`default_nettype none
interface rmcc_rsp_if import rmcc_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [DUTY_BITS-1:0]   duty_one;
   logic [DUTY_BITS-1:0]   duty_two;
   logic [DUTY_BITS-1:0]   duty_three;
   logic [DUTY_BITS-1:0]   duty_four;
   logic [BRIDGE_BITS-1:0] bridge_pins;
   logic [REPLY_BITS-1:0]  reply;
   logic                   turning;

   modport source (output valid, output duty_one, output duty_two, output duty_three,
                   output duty_four, output bridge_pins, output reply, output turning,
                   input ready);
   modport sink   (input valid, input duty_one, input duty_two, input duty_three,
                   input duty_four, input bridge_pins, input reply, input turning,
                   output ready);
endinterface
`default_nettype wire

[rtl/core/rmcc_csr.sv]
// APB register file holding the speed and turn settings.
`default_nettype none
module rmcc_csr import rmcc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output cfg_type                  cfg
);

   logic [DUTY_BITS-1:0]       max_duty_ff, max_duty_in;
   logic [DUTY_BITS-1:0]       min_duty_ff, min_duty_in;
   logic [DUTY_BITS-1:0]       step_size_ff, step_size_in;
   logic [DUTY_BITS-1:0]       turn_duty_ff, turn_duty_in;
   logic [TURN_COUNT_BITS-1:0] turn_ticks_ff, turn_ticks_in;
   logic [DUTY_BITS-1:0]       start_duty_ff, start_duty_in;
   logic [CSR_INDEX_BITS-1:0]  index;
   logic                       wr_en;

   assign pready = 1'b1;
   assign index  = paddr[CSR_ADDR_BITS-1:2];
   assign wr_en  = psel & penable & pwrite & pready;

   always_comb begin
      max_duty_in   = max_duty_ff;
      min_duty_in   = min_duty_ff;
      step_size_in  = step_size_ff;
      turn_duty_in  = turn_duty_ff;
      turn_ticks_in = turn_ticks_ff;
      start_duty_in = start_duty_ff;
      if (wr_en) begin
         unique case (index)
            CSR_MAX_DUTY:   max_duty_in   = DUTY_BITS'(pwdata);
            CSR_MIN_DUTY:   min_duty_in   = DUTY_BITS'(pwdata);
            CSR_STEP_SIZE:  step_size_in  = DUTY_BITS'(pwdata);
            CSR_TURN_DUTY:  turn_duty_in  = DUTY_BITS'(pwdata);
            CSR_TURN_TICKS: turn_ticks_in = TURN_COUNT_BITS'(pwdata);
            CSR_START_DUTY: start_duty_in = DUTY_BITS'(pwdata);
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_MAX_DUTY:   prdata = CSR_DATA_BITS'(max_duty_ff);
         CSR_MIN_DUTY:   prdata = CSR_DATA_BITS'(min_duty_ff);
         CSR_STEP_SIZE:  prdata = CSR_DATA_BITS'(step_size_ff);
         CSR_TURN_DUTY:  prdata = CSR_DATA_BITS'(turn_duty_ff);
         CSR_TURN_TICKS: prdata = CSR_DATA_BITS'(turn_ticks_ff);
         CSR_START_DUTY: prdata = CSR_DATA_BITS'(start_duty_ff);
         default:        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_duty_ff   <= MAX_DUTY_RESET;
         min_duty_ff   <= MIN_DUTY_RESET;
         step_size_ff  <= STEP_SIZE_RESET;
         turn_duty_ff  <= TURN_DUTY_RESET;
         turn_ticks_ff <= TURN_TICKS_RESET;
         start_duty_ff <= START_DUTY_RESET;
      end else begin
         max_duty_ff   <= max_duty_in;
         min_duty_ff   <= min_duty_in;
         step_size_ff  <= step_size_in;
         turn_duty_ff  <= turn_duty_in;
         turn_ticks_ff <= turn_ticks_in;
         start_duty_ff <= start_duty_in;
      end
   end

   // start duty is only read back: reset always loads the default into the motors
   assign cfg.max_duty   = max_duty_ff;
   assign cfg.min_duty   = min_duty_ff;
   assign cfg.step_size  = step_size_ff;
   assign cfg.turn_duty  = turn_duty_ff;
   assign cfg.turn_ticks = turn_ticks_ff;

endmodule
`default_nettype wire

[rtl/core/rmcc_front.sv]
// Front end: accepts input items and classifies them into operations.
`default_nettype none
module rmcc_front import rmcc_pkg::*; (
   rmcc_req_if.sink        req,
   input  logic            queue_full,
   output queue_entry_type push
);

   logic [BYTE_BITS-1:0] upper;
   op_type               op;

   assign upper = (req.rx_byte >= CHAR_LOWER_A && req.rx_byte <= CHAR_LOWER_Z)
                  ? req.rx_byte - CASE_OFFSET : req.rx_byte;

   always_comb begin
      if (req.command == CMD_TICK) begin
         op = OP_TICK;
      end else begin
         unique case (upper)
            CHAR_F:  op = OP_FWD;
            CHAR_B:  op = OP_BACK;
            CHAR_L:  op = OP_LEFT;
            CHAR_R:  op = OP_RIGHT;
            CHAR_U:  op = OP_UP;
            CHAR_D:  op = OP_DOWN;
            CHAR_S:  op = OP_STOP;
            default: op = OP_NONE;
         endcase
      end
   end

   assign req.ready  = ~queue_full;
   assign push.valid = req.valid & ~queue_full;
   assign push.op    = op;

endmodule
`default_nettype wire

[rtl/core/rmcc_queue.sv]
// Short operation queue between the front end and the execution back end.
`default_nettype none
module rmcc_queue import rmcc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  queue_entry_type push,
   input  logic            pop_ready,
   output queue_entry_type head,
   output logic            full
);

   op_type                    entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic                      do_pop;

   assign full       = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.op    = entry_ff[rd_ptr_ff];
   assign do_pop     = head.valid & pop_ready;

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.op;
      end
   end

endmodule
`default_nettype wire

[rtl/core/rmcc_back.sv]
// Back end: executes operations on the motor state and registers each result.
`default_nettype none
module rmcc_back import rmcc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  queue_entry_type head,
   output logic            pop_ready,
   rmcc_rsp_if.source      rsp
);

   logic [DUTY_BITS-1:0]       motor_ff [MOTOR_COUNT];
   logic [DUTY_BITS-1:0]       motor_in [MOTOR_COUNT];
   logic [DUTY_BITS-1:0]       saved_ff [MOTOR_COUNT];
   logic [DUTY_BITS-1:0]       saved_in [MOTOR_COUNT];
   logic [DUTY_BITS-1:0]       reference_ff, reference_in;
   logic                       reverse_ff, reverse_in;
   logic [BRIDGE_BITS-1:0]     bridge_ff, bridge_in;
   logic [TURN_COUNT_BITS-1:0] remaining_ff, remaining_in;
   logic                       active_ff, active_in;
   reply_type                  reply;

   logic                       out_valid_ff, out_valid_in;
   logic [DUTY_BITS-1:0]       out_duty_ff [MOTOR_COUNT];
   logic [BRIDGE_BITS-1:0]     out_bridge_ff;
   logic [REPLY_BITS-1:0]      out_reply_ff;
   logic                       out_turning_ff;

   logic                       fire;
   logic [DUTY_BITS-1:0]       max_a, max_b, max_all, min_a, min_b, min_all;
   logic [DUTY_BITS:0]         up_sum;
   logic [DUTY_BITS-1:0]       up_duty, down_duty;
   logic [TURN_COUNT_BITS-1:0] remaining_dec;
   logic                       spin_a;

   assign pop_ready    = ~out_valid_ff | rsp.ready;
   assign fire         = head.valid & pop_ready;

   assign max_a   = (motor_ff[1] > motor_ff[0]) ? motor_ff[1] : motor_ff[0];
   assign max_b   = (motor_ff[3] > motor_ff[2]) ? motor_ff[3] : motor_ff[2];
   assign max_all = (max_b > max_a) ? max_b : max_a;
   assign min_a   = (motor_ff[1] < motor_ff[0]) ? motor_ff[1] : motor_ff[0];
   assign min_b   = (motor_ff[3] < motor_ff[2]) ? motor_ff[3] : motor_ff[2];
   assign min_all = (min_b < min_a) ? min_b : min_a;

   assign up_sum    = {1'b0, max_all} + {1'b0, cfg.step_size};
   assign up_duty   = up_sum[DUTY_BITS] ? DUTY_MAX_VALUE : up_sum[DUTY_BITS-1:0];
   assign down_duty = (min_all > cfg.step_size) ? min_all - cfg.step_size : '0;

   assign remaining_dec = remaining_ff - TURN_COUNT_BITS'(1);
   // left while forward or right while reverse spins one way, else the other
   assign spin_a = (head.op == OP_LEFT) != reverse_ff;

   always_comb begin
      motor_in     = motor_ff;
      saved_in     = saved_ff;
      reference_in = reference_ff;
      reverse_in   = reverse_ff;
      bridge_in    = bridge_ff;
      remaining_in = remaining_ff;
      active_in    = active_ff;
      reply        = REPLY_NONE;
      if (head.op == OP_TICK) begin
         if (active_ff) begin
            remaining_in = remaining_dec;
            if (remaining_dec == '0) begin
               bridge_in = BRIDGE_OFF;
               motor_in  = saved_ff;
               active_in = 1'b0;
            end
         end
      end else if (!active_ff) begin
         case (head.op)
            OP_FWD: begin
               bridge_in  = BRIDGE_FORWARD;
               reverse_in = 1'b0;
               reply      = REPLY_FWD;
            end
            OP_BACK: begin
               bridge_in  = BRIDGE_REVERSE;
               reverse_in = 1'b1;
               reply      = REPLY_BACK;
            end
            OP_STOP: begin
               bridge_in = BRIDGE_OFF;
               reply     = REPLY_STOP;
            end
            OP_LEFT, OP_RIGHT: begin
               reply        = (head.op == OP_LEFT) ? REPLY_LEFT : REPLY_RIGHT;
               saved_in     = motor_ff;
               reference_in = cfg.turn_duty;
               if (cfg.turn_ticks == '0) begin
                  // zero length turn: starts and ends at once
                  bridge_in = BRIDGE_OFF;
               end else begin
                  bridge_in    = spin_a ? BRIDGE_SPIN_A : BRIDGE_SPIN_B;
                  remaining_in = cfg.turn_ticks;
                  active_in    = 1'b1;
                  for (int i = 0; i < MOTOR_COUNT; i++) begin
                     motor_in[i] = cfg.turn_duty;
                  end
               end
            end
            OP_UP: begin
               if (reference_ff < cfg.max_duty) begin
                  reference_in = up_duty;
                  for (int i = 0; i < MOTOR_COUNT; i++) begin
                     motor_in[i] = up_duty;
                  end
                  reply = REPLY_UP;
               end else begin
                  reply = REPLY_AT_MAX;
               end
            end
            OP_DOWN: begin
               if (reference_ff > cfg.min_duty) begin
                  reference_in = down_duty;
                  for (int i = 0; i < MOTOR_COUNT; i++) begin
                     motor_in[i] = down_duty;
                  end
                  reply = REPLY_DOWN;
               end else begin
                  reply = REPLY_AT_MIN;
               end
            end
            default: ;
         endcase
      end
   end

   assign out_valid_in = fire | (out_valid_ff & ~rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MOTOR_COUNT; i++) begin
            motor_ff[i] <= START_DUTY_RESET;
            saved_ff[i] <= '0;
         end
         reference_ff <= START_DUTY_RESET;
         reverse_ff   <= 1'b0;
         bridge_ff    <= BRIDGE_FORWARD;
         remaining_ff <= '0;
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            motor_ff     <= motor_in;
            saved_ff     <= saved_in;
            reference_ff <= reference_in;
            reverse_ff   <= reverse_in;
            bridge_ff    <= bridge_in;
            remaining_ff <= remaining_in;
            active_ff    <= active_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_duty_ff    <= motor_in;
         out_bridge_ff  <= bridge_in;
         out_reply_ff   <= reply;
         out_turning_ff <= active_in;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.duty_one    = out_duty_ff[0];
   assign rsp.duty_two    = out_duty_ff[1];
   assign rsp.duty_three  = out_duty_ff[2];
   assign rsp.duty_four   = out_duty_ff[3];
   assign rsp.bridge_pins = out_bridge_ff;
   assign rsp.reply       = out_reply_ff;
   assign rsp.turning     = out_turning_ff;

endmodule
`default_nettype wire

[rtl/core/rover_motor_command_controller_core.sv]
// Top level of the rover motor command controller.
`default_nettype none
// Takes one item per clock while the queue is not full: a received byte (F/B/S
// direction and stop, U/D speed step, L/R timed spin) or a timer tick, and returns
// exactly one result per item with the four applied duties, the H-bridge leg
// pattern, a reply code and the turn flag. The front end decodes the byte and
// writes a two-entry queue; the back end executes one queued operation per cycle
// into a result register while the result side accepts, so each item passes
// through a queue entry and then the result register, and the sustained rate is
// one item per cycle. Up to three items are absorbed while the result side
// stalls. Settings are written over the APB port at byte offsets 4*i; the start
// duty register is read back only, reset always loads the default start duty
// into the motors.
module rover_motor_command_controller_core import rmcc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   rmcc_req_if.sink                 req,
   rmcc_rsp_if.source               rsp,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   cfg_type         cfg;
   queue_entry_type push;
   queue_entry_type head;
   logic            queue_full;
   logic            pop_ready;

   rmcc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rmcc_front u_front (
      .req        (req),
      .queue_full (queue_full),
      .push       (push)
   );

   rmcc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop_ready (pop_ready),
      .head      (head),
      .full      (queue_full)
   );

   rmcc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .head      (head),
      .pop_ready (pop_ready),
      .rsp       (rsp)
   );

`ifndef SYNTHESIS
   // a turn in progress always shows a spin pattern on the bridges
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.turning |->
         (rsp.bridge_pins == BRIDGE_SPIN_A || rsp.bridge_pins == BRIDGE_SPIN_B))
      else $error("turn active without spin bridge pattern");

   // a successful speed step leaves all motors at one duty
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.reply == REPLY_UP || rsp.reply == REPLY_DOWN) |->
         (rsp.duty_one == rsp.duty_two && rsp.duty_two == rsp.duty_three &&
          rsp.duty_three == rsp.duty_four))
      else $error("speed step left unequal duties");

   // a turn that ends in the same transfer it starts in turns the bridges off
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.reply == REPLY_LEFT || rsp.reply == REPLY_RIGHT) && !rsp.turning |->
         rsp.bridge_pins == BRIDGE_OFF)
      else $error("zero length turn left bridges on");

   // a full queue never takes a push
   assert property (@(posedge clock) disable iff (reset)
      queue_full |-> !push.valid)
      else $error("push into full queue");
`endif

endmodule
`default_nettype wire

[tb/rmcc_drive_checker.sv]
// Monitor, drive predictor and result scoreboard for the rover motor command controller.
module rmcc_drive_checker import rmcc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   rmcc_req_if                      req,
   rmcc_rsp_if                      rsp,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   input  logic                     pready,
   output int                       failures,
   output int                       pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [DUTY_BITS-1:0]   duty_one;
      logic [DUTY_BITS-1:0]   duty_two;
      logic [DUTY_BITS-1:0]   duty_three;
      logic [DUTY_BITS-1:0]   duty_four;
      logic [BRIDGE_BITS-1:0] bridge_pins;
      logic [REPLY_BITS-1:0]  reply;
      logic                   turning;
   } drive_word_t;

   // settings as last written over the register port
   logic [DUTY_BITS-1:0]       max_setting;
   logic [DUTY_BITS-1:0]       min_setting;
   logic [DUTY_BITS-1:0]       step_setting;
   logic [DUTY_BITS-1:0]       spin_duty_setting;
   logic [TURN_COUNT_BITS-1:0] spin_ticks_setting;
   logic [DUTY_BITS-1:0]       start_setting;

   // predicted controller state
   logic [DUTY_BITS-1:0]       motor_duty [MOTOR_COUNT];
   logic [DUTY_BITS-1:0]       held_duty  [MOTOR_COUNT];
   logic [DUTY_BITS-1:0]       ref_duty;
   logic                       in_reverse;
   logic [BRIDGE_BITS-1:0]     legs;
   logic [TURN_COUNT_BITS-1:0] spin_left;
   logic                       spinning;

   drive_word_t expected_drive [$];
   int          fail_count;

   initial begin
      fail_count = 0;
      failures   = 0;
      pending    = 0;
   end

   task automatic finish_spin();
      int k;
      legs = BRIDGE_OFF;
      for (k = 0; k < MOTOR_COUNT; k++) motor_duty[k] = held_duty[k];
      spinning  = 1'b0;
      spin_left = '0;
   endtask

   task automatic advance_drive(input logic kind, input logic [BYTE_BITS-1:0] rx,
                                output drive_word_t res);
      logic [BYTE_BITS-1:0] ch;
      logic [DUTY_BITS:0]   peak;
      logic [DUTY_BITS-1:0] floor_d;
      reply_type            rep;
      int                   k;
      rep = REPLY_NONE;
      if (kind == CMD_TICK) begin
         if (spinning) begin
            spin_left = spin_left - 1'b1;
            if (spin_left == '0) finish_spin();
         end
      end else if (!spinning) begin
         ch = rx;
         if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) ch = ch - CASE_OFFSET;
         case (ch)
            CHAR_F: begin
               legs       = BRIDGE_FORWARD;
               in_reverse = 1'b0;
               rep        = REPLY_FWD;
            end
            CHAR_B: begin
               legs       = BRIDGE_REVERSE;
               in_reverse = 1'b1;
               rep        = REPLY_BACK;
            end
            CHAR_S: begin
               legs = BRIDGE_OFF;
               rep  = REPLY_STOP;
            end
            CHAR_L, CHAR_R: begin
               for (k = 0; k < MOTOR_COUNT; k++) begin
                  held_duty[k]  = motor_duty[k];
                  motor_duty[k] = spin_duty_setting;
               end
               ref_duty  = spin_duty_setting;
               legs      = ((ch == CHAR_L) != in_reverse) ? BRIDGE_SPIN_A : BRIDGE_SPIN_B;
               spin_left = spin_ticks_setting;
               spinning  = 1'b1;
               // a zero-length turn ends within the same transfer
               if (spin_left == '0) finish_spin();
               rep = (ch == CHAR_L) ? REPLY_LEFT : REPLY_RIGHT;
            end
            CHAR_U: begin
               if (ref_duty < max_setting) begin
                  peak = {1'b0, motor_duty[0]};
                  for (k = 1; k < MOTOR_COUNT; k++)
                     if (motor_duty[k] > peak) peak = {1'b0, motor_duty[k]};
                  peak = peak + step_setting;
                  if (peak > DUTY_MAX_VALUE) peak = {1'b0, DUTY_MAX_VALUE};
                  ref_duty = peak[DUTY_BITS-1:0];
                  for (k = 0; k < MOTOR_COUNT; k++) motor_duty[k] = ref_duty;
                  rep = REPLY_UP;
               end else begin
                  rep = REPLY_AT_MAX;
               end
            end
            CHAR_D: begin
               if (ref_duty > min_setting) begin
                  floor_d = motor_duty[0];
                  for (k = 1; k < MOTOR_COUNT; k++)
                     if (motor_duty[k] < floor_d) floor_d = motor_duty[k];
                  floor_d  = (floor_d > step_setting) ? floor_d - step_setting : '0;
                  ref_duty = floor_d;
                  for (k = 0; k < MOTOR_COUNT; k++) motor_duty[k] = ref_duty;
                  rep = REPLY_DOWN;
               end else begin
                  rep = REPLY_AT_MIN;
               end
            end
            default: ;
         endcase
      end
      res.duty_one    = motor_duty[0];
      res.duty_two    = motor_duty[1];
      res.duty_three  = motor_duty[2];
      res.duty_four   = motor_duty[3];
      res.bridge_pins = legs;
      res.reply       = rep;
      res.turning     = spinning;
   endtask

   task automatic compare_field(input string name, input logic [15:0] want_v,
                                input logic [15:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      drive_word_t seen;
      drive_word_t want;
      int          k;
      if (reset) begin
         max_setting        = MAX_DUTY_RESET;
         min_setting        = MIN_DUTY_RESET;
         step_setting       = STEP_SIZE_RESET;
         spin_duty_setting  = TURN_DUTY_RESET;
         spin_ticks_setting = TURN_TICKS_RESET;
         start_setting      = START_DUTY_RESET;
         for (k = 0; k < MOTOR_COUNT; k++) begin
            motor_duty[k] = start_setting;
            held_duty[k]  = '0;
         end
         ref_duty   = start_setting;
         in_reverse = 1'b0;
         legs       = BRIDGE_FORWARD;
         spin_left  = '0;
         spinning   = 1'b0;
         expected_drive.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_INDEX_BITS+1:2])
               CSR_MAX_DUTY:   max_setting        = pwdata[DUTY_BITS-1:0];
               CSR_MIN_DUTY:   min_setting        = pwdata[DUTY_BITS-1:0];
               CSR_STEP_SIZE:  step_setting       = pwdata[DUTY_BITS-1:0];
               CSR_TURN_DUTY:  spin_duty_setting  = pwdata[DUTY_BITS-1:0];
               CSR_TURN_TICKS: spin_ticks_setting = pwdata[TURN_COUNT_BITS-1:0];
               // never loaded into the motors: reset loads the default start duty
               CSR_START_DUTY: start_setting      = pwdata[DUTY_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            seen.duty_one    = rsp.duty_one;
            seen.duty_two    = rsp.duty_two;
            seen.duty_three  = rsp.duty_three;
            seen.duty_four   = rsp.duty_four;
            seen.bridge_pins = rsp.bridge_pins;
            seen.reply       = rsp.reply;
            seen.turning     = rsp.turning;
            if (expected_drive.size() == 0) begin
               $display("%0t: result transfer with nothing expected, expected none, got %h",
                        $time, seen);
               fail_count++;
            end else begin
               want = expected_drive.pop_front();
               compare_field("duty_one",    16'(want.duty_one),    16'(seen.duty_one));
               compare_field("duty_two",    16'(want.duty_two),    16'(seen.duty_two));
               compare_field("duty_three",  16'(want.duty_three),  16'(seen.duty_three));
               compare_field("duty_four",   16'(want.duty_four),   16'(seen.duty_four));
               compare_field("bridge_pins", 16'(want.bridge_pins), 16'(seen.bridge_pins));
               compare_field("reply",       16'(want.reply),       16'(seen.reply));
               compare_field("turning",     16'(want.turning),     16'(seen.turning));
            end
         end
         if (req.valid && req.ready) begin
            advance_drive(req.command, req.rx_byte, want);
            expected_drive.push_back(want);
         end
      end
      failures <= fail_count;
      pending  <= expected_drive.size();
   end

endmodule

[tb/tb_rover_motor_command_controller_core.sv]
// Top-level testbench: clock, reset, command and register stimulus, and the verdict.
module tb_rover_motor_command_controller_core;
   timeunit 1ns;
   timeprecision 1ps;
   import rmcc_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned PHASES       = 6;
   localparam int unsigned PHASE_ITEMS  = 200;
   localparam int unsigned IDLE_PERCENT = 29;
   localparam logic [TURN_COUNT_BITS-1:0] LONG_TURN = TURN_COUNT_BITS'(300);

   logic                     clock;
   logic                     reset;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;
   logic                     no_idle;
   int                       fail_total;
   int                       pending_total;
   int                       items_sent;
   int                       settings_loaded;

   rmcc_req_if req_ch ();
   rmcc_rsp_if rsp_ch ();

   rover_motor_command_controller_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   rmcc_drive_checker CHECK (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .rsp      (rsp_ch),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .pready   (pready),
      .failures (fail_total),
      .pending  (pending_total)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // result side back-pressure
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   initial begin
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_rover_motor_command_controller_core failed");
      $finish;
   end

   task automatic send_item(input logic kind, input logic [BYTE_BITS-1:0] data);
      while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.command <= kind;
      req_ch.rx_byte <= data;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_random_item();
      int unsigned          roll;
      logic [BYTE_BITS-1:0] letter;
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
         send_item(CMD_TICK, BYTE_BITS'($urandom));
      end else if (roll < 85) begin
         case ($urandom_range(0, 6))
            0:       letter = CHAR_F;
            1:       letter = CHAR_B;
            2:       letter = CHAR_S;
            3:       letter = CHAR_U;
            4:       letter = CHAR_D;
            5:       letter = CHAR_L;
            default: letter = CHAR_R;
         endcase
         if ($urandom_range(0, 1) == 1) letter = letter | CASE_OFFSET;
         send_item(CMD_BYTE, letter);
      end else begin
         send_item(CMD_BYTE, BYTE_BITS'($urandom));
      end
   endtask

   // stop sending until every expected result has been seen
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_total != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // back-to-back APB writes; the next setup phase follows the access phase directly
   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
   endtask

   task automatic load_settings(input logic [31:0] max_v, input logic [31:0] min_v,
                                input logic [31:0] step_v, input logic [31:0] spin_v,
                                input logic [31:0] ticks_v, input logic [31:0] start_v);
      csr_write(CSR_MAX_DUTY, max_v);
      csr_write(CSR_MIN_DUTY, min_v);
      csr_write(CSR_STEP_SIZE, step_v);
      csr_write(CSR_TURN_DUTY, spin_v);
      csr_write(CSR_TURN_TICKS, ticks_v);
      csr_write(CSR_START_DUTY, start_v);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      settings_loaded++;
   endtask

   // zero with junk above the field, all ones, fully random, or a usual value
   function automatic logic [31:0] pick_setting(input logic [31:0] mask,
                                                input int unsigned usual_top);
      case ($urandom_range(0, 3))
         0:       return $urandom & ~mask;
         1:       return mask;
         2:       return $urandom;
         default: return $urandom_range(0, usual_top);
      endcase
   endfunction

   initial begin
      int unsigned n;
      int unsigned phase;
      logic [31:0] ticks_v;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.command <= CMD_BYTE;
      req_ch.rx_byte <= '0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= '0;
      no_idle        <= 1'b0;
      items_sent      = 0;
      settings_loaded = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every letter, several in both cases, byte extremes, short turns both ways
      load_settings(32'd1000, 32'd100, 32'd50, 32'd400, 32'd2, 32'hFFFF_FD09);
      send_item(CMD_TICK, 8'hFF);
      send_item(CMD_BYTE, CHAR_F);
      send_item(CMD_BYTE, CHAR_B | CASE_OFFSET);
      send_item(CMD_BYTE, CHAR_S | CASE_OFFSET);
      send_item(CMD_BYTE, CHAR_U);
      send_item(CMD_BYTE, CHAR_U | CASE_OFFSET);
      send_item(CMD_BYTE, CHAR_D);
      send_item(CMD_BYTE, CHAR_D | CASE_OFFSET);
      send_item(CMD_BYTE, 8'h00);
      send_item(CMD_BYTE, 8'hFF);
      send_item(CMD_BYTE, CHAR_LOWER_Z + 1'b1);
      send_item(CMD_BYTE, CHAR_LOWER_A - 1'b1);
      send_item(CMD_BYTE, CHAR_L);
      send_item(CMD_BYTE, CHAR_R);
      send_item(CMD_TICK, 8'h00);
      send_item(CMD_TICK, 8'h00);
      send_item(CMD_BYTE, CHAR_B);
      send_item(CMD_BYTE, CHAR_R | CASE_OFFSET);
      send_item(CMD_TICK, 8'h5A);
      send_item(CMD_BYTE, CHAR_F);
      send_item(CMD_TICK, 8'hA5);
      wait_drained();
      // saturation at both ends of the duty range, zero-length turns
      load_settings(32'd1023, 32'd0, 32'd1023, 32'd1023, 32'd0, 32'd0);
      send_item(CMD_BYTE, CHAR_U);
      send_item(CMD_BYTE, CHAR_U);
      send_item(CMD_BYTE, CHAR_D);
      send_item(CMD_BYTE, CHAR_D);
      send_item(CMD_BYTE, CHAR_L | CASE_OFFSET);
      send_item(CMD_BYTE, CHAR_R);
      wait_drained();

      // long turn, run without any idling on either side
      load_settings(32'd1000, 32'd100, 32'd50, 32'd400, 32'(LONG_TURN), 32'd1023);
      no_idle <= 1'b1;
      send_item(CMD_BYTE, CHAR_F);
      send_item(CMD_BYTE, CHAR_L);
      for (n = 0; n < LONG_TURN; n++) begin
         if (n == 100) send_item(CMD_BYTE, CHAR_S);
         send_item(CMD_TICK, BYTE_BITS'($urandom));
      end
      no_idle <= 1'b0;
      send_item(CMD_BYTE, CHAR_F);

      for (phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         ticks_v = ($urandom & 32'hFFFF_0000) |
                   (($urandom_range(0, 3) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4));
         load_settings(pick_setting(32'h3FF, 1023), pick_setting(32'h3FF, 400),
                       pick_setting(32'h3FF, 64), pick_setting(32'h3FF, 1023),
                       ticks_v, pick_setting(32'h3FF, 1023));
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2) wait_drained();
            send_random_item();
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      $display("Covered %0d transfers over %0d register settings: all letters, noise bytes,",
               items_sent, settings_loaded);
      $display("duty saturation at both ends, zero-length and long turns, ticks at rest.");
      if (fail_total == 0) begin
         $display("tb_rover_motor_command_controller_core passed");
      end else begin
         $display("tb_rover_motor_command_controller_core failed");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/rmcc_pkg.sv
rtl/core/rmcc_req_if.sv
rtl/core/rmcc_rsp_if.sv
rtl/core/rmcc_csr.sv
rtl/core/rmcc_front.sv
rtl/core/rmcc_queue.sv
rtl/core/rmcc_back.sv
rtl/core/rover_motor_command_controller_core.sv
tb/rmcc_drive_checker.sv
tb/tb_rover_motor_command_controller_core.sv
